FILE: design/pqf_pkg.sv
// Shared types and constants for the point-in-quadrilateral fiducial test.
// No dependencies; imported by point_in_quad_fiducial_test and pqf_serial_mac.
package pqf_pkg;

    localparam int CHANNELS_DEF   = 8;
    localparam int COORD_BITS_DEF = 16;
    localparam int QUAD_CORNERS   = 4;
    localparam int CORNER_W       = 2;

    // stream packing, lowest bit first
    localparam int S_TDATA_W  = 40;
    localparam int CH_LO      = 0;
    localparam int CN_LO      = 3;
    localparam int X_LO       = 5;
    localparam int Y_LO       = 21;
    localparam int FIELD_W    = 16;
    localparam int M_TDATA_W  = 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(QUAD_CORNERS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EDGE,
        ST_MUL,
        ST_STEP,
        ST_RESULT
    } pqf_state_t;

    // status of the bit-serial product-difference unit
    typedef struct packed {
        logic busy;
        logic done;
        logic neg;
        logic zero;
    } mac_res_t;

endpackage

FILE: design/point_in_quad_fiducial_test.sv
// Point-in-quadrilateral fiducial test. A load item (tuser = 0) writes one
// corner of one channel into the corner table. A test item (tuser = 1) walks
// each edge of the channel's quadrilateral in the order 3-0, 0-1, 1-2,
// 2-3 and returns one result item: 1 when the hit lies inside by the
// even-odd crossing rule. Each edge that the hit's y spans and that has a
// corner at or left of the hit's x is settled by the sign of the product
// difference (y-yk)(xj-xk) - (x-xk)(yj-yk), worked out by one bit-serial
// unit on COORD_BITS+1-bit operands that takes one multiplier bit per cycle. A
// channel of CHANNELS or above gives 0 without walking any edge. A finished
// result waits in an output register while the next item is accepted.
// Corners are read from a memory with a registered read port; they must be
// loaded before a test. Uses pqf_pkg, pqf_corner_mem and pqf_serial_mac.
module point_in_quad_fiducial_test
    import pqf_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // channel[2:0], corner[4:3], x_coord[20:5], y_coord[36:21], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // operation[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // inside_res[0], zero fill
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int DEPTH  = CHANNELS * QUAD_CORNERS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int W      = COORD_BITS;

    // input field split
    logic [2:0]          in_ch;
    logic [CORNER_W-1:0] in_cn;
    logic signed [W-1:0] in_x, in_y;
    logic                in_ch_ok, accept;

    assign in_ch    = s_tdata[CH_LO +: 3];
    assign in_cn    = s_tdata[CN_LO +: CORNER_W];
    // keep the low COORD_BITS bits, or sign-extend when wider than the field
    assign in_x     = W'($signed(s_tdata[X_LO +: FIELD_W]));
    assign in_y     = W'($signed(s_tdata[Y_LO +: FIELD_W]));
    assign in_ch_ok = (32'(in_ch) < CHANNELS);
    assign accept   = s_tvalid && s_tready;

    pqf_state_t state_reg, state_next;

    logic [2:0]          ch_reg;
    logic [CORNER_W-1:0] idx_reg;
    logic                first_reg;
    logic                odd_reg;
    logic                dy_neg_reg;
    logic signed [W-1:0] hx_reg, hy_reg;     // hit point
    logic signed [W-1:0] jx_reg, jy_reg;     // previous corner
    logic signed [W-1:0] kx_reg, ky_reg;     // current corner
    logic                m_tvalid_reg, inside_reg;

    // corner table
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr, rd_addr;
    logic [2*W-1:0]      rd_data;
    logic signed [W-1:0] rx, ry;

    assign wr_en   = accept && (s_tuser == OP_LOAD) && in_ch_ok;
    assign wr_addr = ADDR_W'({in_ch, in_cn});
    assign rd_addr = ADDR_W'({ch_reg, idx_reg});
    assign rx      = rd_data[W-1:0];
    assign ry      = rd_data[2*W-1:W];

    pqf_corner_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (2 * W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({in_y, in_x}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // edge qualification: k is the corner just read, j the one before
    logic spans, left, consider, mac_start, out_free;
    logic signed [W:0] d_a, d_b, d_c, d_d;

    always_comb begin
        spans = ((ry < hy_reg) && (jy_reg >= hy_reg)) ||
                ((jy_reg < hy_reg) && (ry >= hy_reg));
        left  = (rx <= hx_reg) || (jx_reg <= hx_reg);
        consider = spans && left;
        d_a = (W+1)'(hy_reg) - (W+1)'(ry);      // y - yk
        d_b = (W+1)'(jx_reg) - (W+1)'(rx);      // xj - xk
        d_c = (W+1)'(hx_reg) - (W+1)'(rx);      // x - xk
        d_d = (W+1)'(jy_reg) - (W+1)'(ry);      // yj - yk
    end

    mac_res_t mac_res;

    pqf_serial_mac #(
        .COORD_BITS (COORD_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start),
        .a_in    (d_a),
        .b_in    (d_b),
        .c_in    (d_c),
        .d_in    (d_d),
        .res     (mac_res)
    );

    // dy > 0: cross when the difference is negative; dy < 0: when positive
    logic crossing;
    assign crossing = dy_neg_reg ? (!mac_res.neg && !mac_res.zero) : mac_res.neg;
    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_tuser == OP_TEST)) begin
                    state_next = in_ch_ok ? ST_FETCH : ST_RESULT;
                end
            end
            ST_FETCH: state_next = ST_EDGE;
            ST_EDGE: begin
                if (first_reg) begin
                    state_next = ST_FETCH;
                end else if (consider) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_MUL: begin
                if (mac_res.done) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: state_next = (idx_reg == LAST_CORNER) ? ST_RESULT : ST_FETCH;
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready  = 1'b0;
        mac_start = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready  = 1'b1;
            ST_EDGE: mac_start = !first_reg && consider;
            default: begin
                s_tready  = 1'b0;
                mac_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_RESULT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ch_reg    <= in_ch;
                    hx_reg    <= in_x;
                    hy_reg    <= in_y;
                    idx_reg   <= LAST_CORNER;    // start with the closing corner
                    first_reg <= 1'b1;
                    odd_reg   <= 1'b0;
                end
            end
            ST_EDGE: begin
                if (first_reg) begin
                    jx_reg    <= rx;
                    jy_reg    <= ry;
                    first_reg <= 1'b0;
                    idx_reg   <= '0;
                end else begin
                    kx_reg     <= rx;
                    ky_reg     <= ry;
                    dy_neg_reg <= d_d[W];
                end
            end
            ST_MUL: begin
                if (mac_res.done) begin
                    odd_reg <= odd_reg ^ crossing;
                end
            end
            ST_STEP: begin
                jx_reg  <= kx_reg;
                jy_reg  <= ky_reg;
                idx_reg <= idx_reg + CORNER_W'(1);
            end
            ST_RESULT: begin
                if (out_free) begin
                    // out-of-range channel never left IDLE for a fetch: odd is 0
                    inside_reg <= odd_reg;
                end
            end
            default: begin
                odd_reg <= odd_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, inside_reg};

    // a new result is only ever launched from the result state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result raised outside the result state");

    // the serial unit reports completion only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        mac_res.done |-> (state_reg == ST_MUL))
        else $error("multiply finished outside the multiply state");

    // waiting on the multiplier implies it is actually running
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (mac_res.busy || mac_res.done))
        else $error("multiply state with idle serial unit");

endmodule

FILE: design/pqf_corner_mem.sv
// Corner table: one write port, one registered read port, {y, x} per entry.
// Depends on nothing but its parameters.
module pqf_corner_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/pqf_serial_mac.sv
// Bit-serial evaluation of a*b - c*d: b and d are consumed one bit per cycle,
// LSB first, into a right-shifting accumulator. Uses pqf_pkg (mac_res_t).
module pqf_serial_mac
    import pqf_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [COORD_BITS:0] a_in,
    input  logic signed [COORD_BITS:0] b_in,
    input  logic signed [COORD_BITS:0] c_in,
    input  logic signed [COORD_BITS:0] d_in,
    output mac_res_t                   res
);

    localparam int DW = COORD_BITS + 1;
    localparam int AW = COORD_BITS + 4;
    localparam int CW = $clog2(DW);

    logic signed [DW-1:0] a_reg, c_reg;
    logic [DW-1:0]        b_sh_reg, d_sh_reg;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg, done_reg, lownz_reg;

    logic                 last;
    logic signed [AW-1:0] a_ext, c_ext, part, term, sum;

    always_comb begin
        last     = (cnt_reg == CW'(DW - 1));
        a_ext    = AW'(a_reg);
        c_ext    = AW'(c_reg);
        part     = (b_sh_reg[0] ? a_ext : '0) - (d_sh_reg[0] ? c_ext : '0);
        // the top multiplier bit carries negative weight
        term     = last ? -part : part;
        sum      = acc_reg + term;
        acc_next = sum >>> 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg     <= a_in;
            c_reg     <= c_in;
            b_sh_reg  <= b_in;
            d_sh_reg  <= d_in;
            acc_reg   <= '0;
            lownz_reg <= 1'b0;
        end else if (busy_reg) begin
            b_sh_reg  <= b_sh_reg >> 1;
            d_sh_reg  <= d_sh_reg >> 1;
            acc_reg   <= acc_next;
            lownz_reg <= lownz_reg | sum[0];
        end
    end

    // low product bits are gone, only their OR is needed for the zero test
    assign res.busy = busy_reg;
    assign res.done = done_reg;
    assign res.neg  = acc_reg[AW-1];
    assign res.zero = (acc_reg == '0) && !lownz_reg;

endmodule
